// ===== hw/rtl/rlp_pkg.sv =====
// Package for the run-length bit packer: encoder step type and function.
// Depends on nothing; used by the top level.
`default_nettype none

package rlp_pkg;

  // Longest repeat run that fits in one count token.
  localparam int unsigned RunChunk = 8;

  // Widest group of code bits that one encoder step produces (token + byte).
  localparam int unsigned StepBits = 11;

  // Result of one encoder step: code bits (right aligned), their count,
  // and the updated run state.
  typedef struct packed {
    logic [StepBits-1:0] bits;
    logic [3:0]          cnt;
    logic [3:0]          run_length;
    logic                literal_open;
  } enc_t;

  // Encode one byte given whether the byte after it is equal.
  // An open literal run always has a run length of one, so closing it
  // never coincides with a full chunk.
  function automatic enc_t encode(input logic [7:0] ch, input logic next_equal,
                                  input logic [3:0] run_length,
                                  input logic literal_open);
    enc_t r;
    r.bits         = '0;
    r.cnt          = 4'd0;
    r.run_length   = run_length;
    r.literal_open = literal_open;
    if (next_equal) begin
      if (literal_open) begin
        // Count token of one closes the literal run.
        r.bits         = StepBits'(3'd0);
        r.cnt          = 4'd3;
        r.literal_open = 1'b0;
      end
      r.run_length = run_length + 4'd1;
      if (r.run_length > 4'(RunChunk)) begin
        r.bits       = {3'(RunChunk - 1), ch};
        r.cnt        = 4'd11;
        r.run_length = 4'd1;
      end
    end else if (run_length > 4'd1) begin
      r.bits         = {3'(run_length - 4'd1), ch};
      r.cnt          = 4'd11;
      r.literal_open = 1'b0;
      r.run_length   = 4'd1;
    end else if (literal_open) begin
      r.bits = StepBits'(ch);
      r.cnt  = 4'd8;
    end else begin
      r.bits         = {3'd0, ch};
      r.cnt          = 4'd11;
      r.literal_open = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rlp_if.sv =====
// Valid/ready channel interfaces for the run-length bit packer.
// Depends on nothing; used by the top level and its environment.
`default_nettype none

// Input channel: one raw message byte per word.
interface rlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

// Output channel: one packed code byte per word.
interface rlp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rle_literal_run_bit_packer.sv =====
// Run-length encoder with literal runs and an MSB-first bit packer.
// Depends on rlp_pkg and the channel interfaces in rlp_if.sv.
//
// Each input word is encoded in the cycle it is accepted: the held-back
// byte and, at the end of a message, the final byte are turned into code
// bits, joined to the leftover bits of earlier words, and the whole bytes
// are loaded into an output register of up to four bytes. That register
// drains one byte per cycle while the receiver is ready, and a new input
// word is accepted in the same cycle as the last byte of the previous one
// leaves (or at once if a word made no byte). A word therefore holds off
// the next one until all its bytes have left: ordinary words make at most
// two bytes, data that does not compress makes one byte per word (an open
// literal run adds a byte per word), and a message's last word up to four.
`default_nettype none

module rle_literal_run_bit_packer (
  input wire logic  clk,
  input wire logic  rst,
  rlp_in_if.sink    in_ch,
  rlp_out_if.source out_ch
);

  localparam int unsigned AccBits = 32;

  // Encoder state.
  logic [7:0] held_byte;
  logic       held_valid;
  logic [3:0] run_length;
  logic       literal_open;
  logic [6:0] pending_bits;
  logic [2:0] pending_count;

  // Output byte register: left-aligned bytes, count and end flag.
  logic [AccBits-1:0] out_data;
  logic [2:0]         out_cnt;
  logic               out_fin;

  logic in_fire;
  logic out_fire;

  rlp_pkg::enc_t e1;
  rlp_pkg::enc_t e2;

  logic [AccBits-1:0] acc1;
  logic [AccBits-1:0] acc2;
  logic [4:0]         total;
  logic [AccBits-1:0] aligned;
  logic [2:0]         n_bytes;
  logic [2:0]         rem;
  logic [6:0]         pend_next;

  // Handshake: accept when the output register will be empty this cycle.
  assign out_fire     = out_ch.valid && out_ch.ready;
  assign in_ch.ready  = (out_cnt == 3'd0) || ((out_cnt == 3'd1) && out_ch.ready);
  assign in_fire      = in_ch.valid && in_ch.ready;

  assign out_ch.valid    = (out_cnt != 3'd0);
  assign out_ch.out_byte = out_data[AccBits-1 -: 8];
  assign out_ch.out_last = out_fin && (out_cnt == 3'd1);

  // Encode the held byte against the new one, then the final byte if any.
  always_comb begin
    e1 = '0;
    e1.run_length   = run_length;
    e1.literal_open = literal_open;
    if (held_valid) begin
      e1 = rlp_pkg::encode(held_byte, held_byte == in_ch.in_char, run_length,
                           literal_open);
    end
    e2 = '0;
    e2.run_length   = e1.run_length;
    e2.literal_open = e1.literal_open;
    if (in_ch.in_last) begin
      e2 = rlp_pkg::encode(in_ch.in_char, 1'b0, e1.run_length, e1.literal_open);
    end
  end

  // Join leftover bits with the new code bits and split into bytes.
  always_comb begin
    acc1    = (AccBits'(pending_bits) << e1.cnt) | AccBits'(e1.bits);
    acc2    = (acc1 << e2.cnt) | AccBits'(e2.bits);
    total   = 5'(pending_count) + 5'(e1.cnt) + 5'(e2.cnt);
    aligned = acc2 << (6'd32 - {1'b0, total});
    rem     = total[2:0];
    n_bytes = {1'b0, total[4:3]} + {2'b00, (in_ch.in_last && (rem != 3'd0))};
    pend_next = 7'(acc2 & ((AccBits'(1) << rem) - AccBits'(1)));
  end

  // Encoder state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte     <= 8'd0;
      held_valid    <= 1'b0;
      run_length    <= 4'd1;
      literal_open  <= 1'b0;
      pending_bits  <= 7'd0;
      pending_count <= 3'd0;
    end else if (in_fire) begin
      if (in_ch.in_last) begin
        held_byte     <= 8'd0;
        held_valid    <= 1'b0;
        run_length    <= 4'd1;
        literal_open  <= 1'b0;
        pending_bits  <= 7'd0;
        pending_count <= 3'd0;
      end else begin
        held_byte     <= in_ch.in_char;
        held_valid    <= 1'b1;
        run_length    <= e1.run_length;
        literal_open  <= e1.literal_open;
        pending_bits  <= pend_next;
        pending_count <= rem;
      end
    end
  end

  // Output byte register: load on accept, shift out one byte per word sent.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= 3'd0;
      out_fin <= 1'b0;
    end else if (in_fire) begin
      out_cnt <= n_bytes;
      out_fin <= in_ch.in_last;
    end else if (out_fire) begin
      out_cnt <= out_cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= aligned;
    end else if (out_fire) begin
      out_data <= out_data << 8;
    end
  end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Testbench for rle_literal_run_bit_packer: drives byte messages, predicts the packed code stream.
// Depends on the channel interfaces in rlp_if.sv and the top level of the block.
`timescale 1ns / 1ps

module testbench;

  // One packed code byte as it should leave the block.
  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } code_word_t;

  localparam int unsigned MaxRunLen  = 8;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned LongHold   = 80;

  logic clk = 1'b0;
  logic rst;

  rlp_in_if  in_ch ();
  rlp_out_if out_ch ();

  rle_literal_run_bit_packer dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Encoder state of the predictor.
  logic [7:0]  held_char;
  bit          held_ok;
  logic [3:0]  run_len;
  bit          lit_open;
  logic [6:0]  spare_bits;
  logic [2:0]  spare_cnt;
  logic [63:0] acc;
  int unsigned acc_n;

  code_word_t  due_bytes[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned words_sent = 0;
  int unsigned hold_cycles = 0;
  bit          quiet_phase = 1'b0;
  bit          sender_gaps = 1'b1;

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up on a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void clear_encoder_state();
    held_char  = 8'h00;
    held_ok    = 1'b0;
    run_len    = 4'd1;
    lit_open   = 1'b0;
    spare_bits = 7'd0;
    spare_cnt  = 3'd0;
  endfunction

  function automatic void append_bits(input logic [7:0] value, input int unsigned width);
    acc   = (acc << width) | (64'(value) & ((64'd1 << width) - 64'd1));
    acc_n = acc_n + width;
  endfunction

  // Code bits for one byte, given whether the byte after it is equal.
  function automatic void code_char(input logic [7:0] ch, input bit next_same);
    if (next_same) begin
      if (lit_open) begin
        append_bits(8'd0, 3);
        lit_open = 1'b0;
      end
      run_len = run_len + 4'd1;
      if (run_len > 4'(MaxRunLen)) begin
        append_bits(8'(MaxRunLen - 1), 3);
        append_bits(ch, 8);
        run_len = 4'd1;
      end
    end else if (run_len > 4'd1) begin
      append_bits(8'(run_len - 4'd1), 3);
      append_bits(ch, 8);
      lit_open = 1'b0;
      run_len  = 4'd1;
    end else if (lit_open) begin
      append_bits(ch, 8);
    end else begin
      lit_open = 1'b1;
      append_bits(8'd0, 3);
      append_bits(ch, 8);
    end
  endfunction

  // Work out the code bytes that one accepted input word releases.
  function automatic void pack_code_bytes(input logic [7:0] ch, input logic last);
    code_word_t got[4];
    int unsigned n;
    n     = 0;
    acc   = 64'(spare_bits);
    acc_n = 32'(spare_cnt);
    if (held_ok) code_char(held_char, held_char == ch);
    if (last) begin
      code_char(ch, 1'b0);
    end else begin
      held_char = ch;
      held_ok   = 1'b1;
    end
    while (acc_n >= 8) begin
      got[n].code = 8'(acc >> (acc_n - 8));
      got[n].last = 1'b0;
      n++;
      acc_n -= 8;
    end
    if (last) begin
      // Flush the partial byte with zero padding; the final byte closes the message.
      if (acc_n > 0) begin
        got[n].code = 8'(acc << (8 - acc_n));
        got[n].last = 1'b0;
        n++;
      end
      if (n > 0) got[n - 1].last = 1'b1;
      clear_encoder_state();
    end else begin
      spare_bits = 7'(acc & ((64'd1 << acc_n) - 64'd1));
      spare_cnt  = 3'(acc_n);
    end
    for (int unsigned i = 0; i < n; i++) due_bytes.push_back(got[i]);
  endfunction

  // Compare each accepted code byte with the oldest expected one.
  always @(posedge clk) begin : check_output
    code_word_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (due_bytes.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual byte %h last %b",
                 $time, out_ch.out_byte, out_ch.out_last);
        errors++;
      end else begin
        want = due_bytes.pop_front();
        if (out_ch.out_byte !== want.code) begin
          $display("%0t: out_byte mismatch: expected %h, actual %h",
                   $time, want.code, out_ch.out_byte);
          errors++;
        end
        if (out_ch.out_last !== want.last) begin
          $display("%0t: out_last mismatch: expected %b, actual %b",
                   $time, want.last, out_ch.out_last);
          errors++;
        end
      end
    end
  end

  // Receiver: random short stalls, and a long hold when one is requested.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles = $urandom_range(0, 2);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one input word and wait until it is taken; may leave a short gap after it.
  task automatic send_word(input logic [7:0] ch, input logic last);
    in_ch.valid   <= 1'b1;
    in_ch.in_char <= ch;
    in_ch.in_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    pack_code_bytes(ch, last);
    words_sent++;
    if (!quiet_phase && sender_gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid   <= 1'b0;
      in_ch.in_char <= 8'($urandom);
      in_ch.in_last <= 1'($urandom);
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drop_valid();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // A message built from runs of random length and content.
  task automatic send_random_message();
    int unsigned len;
    int unsigned sent;
    int unsigned run;
    int unsigned pick;
    logic [7:0]  value;
    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 14);
    sent = 0;
    sender_gaps = ($urandom_range(0, 2) != 0);
    while (sent < len) begin
      pick = $urandom_range(0, 19);
      if (pick < 8) run = 1;
      else if (pick < 15) run = $urandom_range(2, 4);
      else if (pick < 18) run = $urandom_range(5, 9);
      else run = $urandom_range(10, 20);
      pick = $urandom_range(0, 3);
      if (pick == 0) value = 8'h00;
      else if (pick == 1) value = 8'hff;
      else if (pick == 2) value = 8'($urandom_range(0, 3));
      else value = 8'($urandom);
      for (int unsigned i = 0; i < run && sent < len; i++) begin
        send_word(value, sent == len - 1);
        sent++;
      end
    end
  endtask

  // One-byte messages at both ends of the byte range.
  task automatic test_single_byte_messages();
    send_word(8'h00, 1'b1);
    send_word(8'hff, 1'b1);
  endtask

  // A run longer than one chunk, then a literal run that ends the message unclosed.
  task automatic test_long_run_then_literal();
    for (int i = 0; i < 9; i++) send_word(8'h55, 1'b0);
    send_word(8'haa, 1'b1);
  endtask

  // Literal run closed by a repeat run; the message ends exactly on a byte boundary.
  task automatic test_exact_byte_boundary();
    send_word(8'h0f, 1'b0);
    send_word(8'hf0, 1'b0);
    for (int i = 0; i < 6; i++) begin
      send_word(8'(8'h31 + i), 1'b0);
      send_word(8'(8'h31 + i), i == 5);
    end
  endtask

  // Receiver holds off while words keep coming; then the sender waits for a full drain.
  task automatic test_backpressure();
    int unsigned start;
    start = words_sent;
    hold_cycles = LongHold;
    while (words_sent - start < 40) send_random_message();
    drop_valid();
    while (due_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_random_messages(input int unsigned count);
    int unsigned start;
    start = words_sent;
    while (words_sent - start < count) send_random_message();
  endtask

  // Back-to-back traffic with no gaps on either side.
  task automatic test_random_no_idle(input int unsigned count);
    quiet_phase = 1'b1;
    test_random_messages(count);
  endtask

  initial begin
    rst           <= 1'b1;
    in_ch.valid   <= 1'b0;
    in_ch.in_char <= 8'h00;
    in_ch.in_last <= 1'b0;
    clear_encoder_state();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_single_byte_messages();
    test_long_run_then_literal();
    test_exact_byte_boundary();
    test_backpressure();
    test_random_messages(260);
    test_random_no_idle(60);

    // Let the last code bytes drain, then watch for strays.
    drop_valid();
    while (due_bytes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/rlp_pkg.sv
hw/rtl/rlp_if.sv
hw/rtl/rle_literal_run_bit_packer.sv
dv/testbench.sv
